[design/rcf_pkg.sv]
`default_nettype none
package rcf_pkg;

    localparam int BYTE_W  = 8;
    localparam int ANGLE_W = 8;
    localparam int VALUE_W = 10;
    localparam int FPOS_W  = 3;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_STICKS = 4;

    // Character codes
    localparam logic [BYTE_W-1:0] LOW_LIMIT = 8'd47;
    localparam logic [BYTE_W-1:0] CH_START  = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] CH_SEP    = 8'h3A;  // ':'
    localparam logic [BYTE_W-1:0] CH_END    = 8'h2F;  // '/'
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'

    localparam logic [VALUE_W-1:0] VALUE_MAX   = 10'd1000;
    localparam logic [FPOS_W-1:0]  FIELD_LIMIT = 3'd5;
    localparam logic [FPOS_W-1:0]  MODE_FIELD  = 3'd4;
    localparam logic [MODE_W-1:0]  MODE_SAT    = 3'd4;

    // Mode field values
    localparam logic [MODE_W-1:0] MODE_GPS      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ATTITUDE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GPS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL   = 2'd2;

    localparam logic [ANGLE_W-1:0] GPS_RESET      = 8'd127;
    localparam logic [ANGLE_W-1:0] ATTITUDE_RESET = 8'd94;
    localparam logic [ANGLE_W-1:0] MANUAL_RESET   = 8'd62;
    localparam logic [ANGLE_W-1:0] HELD_RESET     = 8'd127;

    // floor(v*95/1000) = floor(v*19/200) = (v * 19 * ceil(2^21/200)) >> 21 for v <= 1000.
    localparam logic [ANGLE_W-1:0] ANGLE_BASE  = 8'd45;
    localparam int                 RECIP_SHIFT = 21;
    localparam int                 PROD_W      = 28;
    localparam logic [17:0]        ANGLE_RECIP = 18'd199234;

endpackage
`default_nettype wire

[design/rcf_rx_if.sv]
`default_nettype none
interface rcf_rx_if;
    logic                        valid;
    logic                        ready;
    logic [rcf_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[design/rcf_res_if.sv]
`default_nettype none
interface rcf_res_if;
    logic                         valid;
    logic                         ready;
    logic [rcf_pkg::ANGLE_W-1:0]  aileron_angle;
    logic [rcf_pkg::ANGLE_W-1:0]  elevator_angle;
    logic [rcf_pkg::ANGLE_W-1:0]  throttle_angle;
    logic [rcf_pkg::ANGLE_W-1:0]  rudder_angle;
    logic [rcf_pkg::ANGLE_W-1:0]  mode_angle;

    modport source (output valid, output aileron_angle, output elevator_angle,
                    output throttle_angle, output rudder_angle, output mode_angle,
                    input ready);
    modport sink   (input valid, input aileron_angle, input elevator_angle,
                    input throttle_angle, input rudder_angle, input mode_angle,
                    output ready);
endinterface
`default_nettype wire

[design/rc_command_frame_parser.sv]
`default_nettype none
// Command frame parser: one received byte is taken per cycle while the input is not stalled.
// The snapshot stage takes the frame when its frame-closing '/' is transferred; the angle
// multiply then fills the output register from the snapshot stage, which holds the frame
// while the output register is full. Throughput is one byte per cycle; the input
// stalls only while results wait in both the output register and the snapshot stage.
// Reset is synchronous and active low: idle parser, clear frame, default mode angles.
module rc_command_frame_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    rcf_rx_if.sink                                 i_rx,
    rcf_res_if.source                              o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [rcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rcf_pkg::ANGLE_W-1:0]       i_cfg_data
);

    typedef logic [rcf_pkg::VALUE_W-1:0] t_value;
    typedef logic [rcf_pkg::ANGLE_W-1:0] t_angle;

    // Configuration registers
    t_angle r_gps_angle;
    t_angle r_att_angle;
    t_angle r_man_angle;

    // Parser state
    logic                         r_await,  n_await;
    logic [rcf_pkg::FPOS_W-1:0]   r_fpos,   n_fpos;
    logic                         r_tok,    n_tok;
    logic                         r_stop,   n_stop;
    t_value                       r_stick [rcf_pkg::NUM_STICKS];
    t_value                       n_stick [rcf_pkg::NUM_STICKS];
    logic [rcf_pkg::MODE_W-1:0]   r_mode,   n_mode;
    t_angle                       r_held,   n_held;
    logic                         capture;

    // Snapshot stage and output register
    logic                         r_s1_valid;
    t_value                       r_s1_stick [rcf_pkg::NUM_STICKS];
    t_angle                       r_s1_mode;
    logic                         r_out_valid;
    t_angle                       r_out_angle [rcf_pkg::NUM_STICKS];
    t_angle                       r_out_mode;

    logic                         s1_adv;
    logic                         in_ready;
    logic                         acc;

    logic [rcf_pkg::BYTE_W-1:0]   rx_b;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic                         stop_eff;
    t_value                       cur_val;
    logic [13:0]                  val_next;
    logic [5:0]                   mode_next;

    function automatic t_angle stick_angle(input t_value v);
        logic [rcf_pkg::PROD_W-1:0] p;
        p = rcf_pkg::PROD_W'(v) * rcf_pkg::PROD_W'(rcf_pkg::ANGLE_RECIP);
        return rcf_pkg::ANGLE_BASE
               + rcf_pkg::ANGLE_W'(p[rcf_pkg::PROD_W-1:rcf_pkg::RECIP_SHIFT]);
    endfunction

    assign s1_adv     = !r_out_valid || o_res.ready;
    assign in_ready   = !r_s1_valid || s1_adv;
    assign i_rx.ready = in_ready;
    assign acc        = i_rx.valid && in_ready;

    assign rx_b     = i_rx.rx_byte;
    assign is_digit = (rx_b >= rcf_pkg::CH_ZERO) && (rx_b <= rcf_pkg::CH_NINE);
    assign digit    = 4'(rx_b - rcf_pkg::CH_ZERO);
    // A fresh field starts its digit run again.
    assign stop_eff = r_tok ? r_stop : 1'b0;
    assign cur_val  = r_stick[r_fpos[1:0]];
    assign val_next = ({4'd0, cur_val} << 3) + ({4'd0, cur_val} << 1) + 14'(digit);
    assign mode_next = ({3'd0, r_mode} << 3) + ({3'd0, r_mode} << 1) + 6'(digit);

    always_comb begin
        n_await = r_await;
        n_fpos  = r_fpos;
        n_tok   = r_tok;
        n_stop  = r_stop;
        n_stick = r_stick;
        n_mode  = r_mode;
        n_held  = r_held;
        capture = 1'b0;
        if (acc && (rx_b >= rcf_pkg::LOW_LIMIT)) begin
            if (r_await) begin
                if (rx_b == rcf_pkg::CH_START) begin
                    n_await = 1'b0;
                end
            end else if (rx_b == rcf_pkg::CH_START) begin
                // A start marker inside a frame is skipped.
                n_await = 1'b0;
            end else if (rx_b == rcf_pkg::CH_END) begin
                case (r_mode)
                    rcf_pkg::MODE_GPS:      n_held = r_gps_angle;
                    rcf_pkg::MODE_ATTITUDE: n_held = r_att_angle;
                    rcf_pkg::MODE_MANUAL:   n_held = r_man_angle;
                    default:                n_held = r_held;
                endcase
                capture = 1'b1;
                n_await = 1'b1;
                n_fpos  = '0;
                n_tok   = 1'b0;
                n_stop  = 1'b0;
                n_mode  = '0;
                for (int k = 0; k < rcf_pkg::NUM_STICKS; k++) begin
                    n_stick[k] = '0;
                end
            end else if (rx_b == rcf_pkg::CH_SEP) begin
                if (r_tok && (r_fpos < rcf_pkg::FIELD_LIMIT)) begin
                    n_fpos = r_fpos + 3'd1;
                end
                n_tok  = 1'b0;
                n_stop = 1'b0;
            end else begin
                n_tok = 1'b1;
                if (is_digit && !stop_eff) begin
                    n_stop = 1'b0;
                    if (r_fpos < rcf_pkg::MODE_FIELD) begin
                        n_stick[r_fpos[1:0]] = (val_next > 14'(rcf_pkg::VALUE_MAX))
                                             ? rcf_pkg::VALUE_MAX : val_next[9:0];
                    end else if (r_fpos == rcf_pkg::MODE_FIELD) begin
                        n_mode = (mode_next > 6'(rcf_pkg::MODE_SAT))
                               ? rcf_pkg::MODE_SAT : mode_next[2:0];
                    end
                end else begin
                    n_stop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gps_angle <= rcf_pkg::GPS_RESET;
            r_att_angle <= rcf_pkg::ATTITUDE_RESET;
            r_man_angle <= rcf_pkg::MANUAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcf_pkg::CFG_GPS:      r_gps_angle <= i_cfg_data;
                rcf_pkg::CFG_ATTITUDE: r_att_angle <= i_cfg_data;
                rcf_pkg::CFG_MANUAL:   r_man_angle <= i_cfg_data;
                default:               r_gps_angle <= r_gps_angle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
            r_fpos  <= '0;
            r_tok   <= 1'b0;
            r_stop  <= 1'b0;
            r_mode  <= '0;
            r_held  <= rcf_pkg::HELD_RESET;
            for (int k = 0; k < rcf_pkg::NUM_STICKS; k++) begin
                r_stick[k] <= '0;
            end
        end else begin
            r_await <= n_await;
            r_fpos  <= n_fpos;
            r_tok   <= n_tok;
            r_stop  <= n_stop;
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_stick <= n_stick;
        end
    end

    // The snapshot stage holds the finished frame while the output register drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_s1_stick <= r_stick;
            r_s1_mode  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            for (int k = 0; k < rcf_pkg::NUM_STICKS; k++) begin
                r_out_angle[k] <= stick_angle(r_s1_stick[k]);
            end
            r_out_mode <= r_s1_mode;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.aileron_angle  = r_out_angle[0];
    assign o_res.elevator_angle = r_out_angle[1];
    assign o_res.throttle_angle = r_out_angle[2];
    assign o_res.rudder_angle   = r_out_angle[3];
    assign o_res.mode_angle     = r_out_mode;

    a_close_snapshot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> r_s1_valid)
        else $error("closed frame did not reach the snapshot stage");

    a_close_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> (r_await && (r_fpos == '0) && (r_mode == '0)))
        else $error("frame state not cleared after frame close");

    a_fpos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fpos <= rcf_pkg::FIELD_LIMIT) && (r_mode <= rcf_pkg::MODE_SAT))
        else $error("field position or mode value out of range");

    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> ($stable(r_s1_mode) && r_s1_valid))
        else $error("snapshot overwritten while output stalled");

endmodule
`default_nettype wire

[dv/tb.sv]
module tb;
    import rcf_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 6;
    localparam int STICK_SPAN      = 95;
    localparam int FLOOD_FRAMES    = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] aileron;
        logic [ANGLE_W-1:0] elevator;
        logic [ANGLE_W-1:0] throttle;
        logic [ANGLE_W-1:0] rudder;
        logic [ANGLE_W-1:0] mode;
    } t_angles;

    typedef struct {
        string   text;
        bit      typed;
        t_angles want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ANGLE_W-1:0]   i_cfg_data;

    rcf_rx_if  rx ();
    rcf_res_if res ();

    rc_command_frame_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Frame tracking state, mirrored from the block's behavior.
    logic [ANGLE_W-1:0] gps_angle_reg;
    logic [ANGLE_W-1:0] att_angle_reg;
    logic [ANGLE_W-1:0] man_angle_reg;
    logic [ANGLE_W-1:0] held_angle;
    bit                 awaiting_start;
    bit                 token_open;
    bit                 digits_stopped;
    logic [FPOS_W-1:0]  field_pos;
    logic [VALUE_W-1:0] stick_val [NUM_STICKS];
    logic [MODE_W-1:0]  mode_val;

    t_angles     expected_angles [$];
    t_angles     typed_want;
    bit          typed_pending;
    bit          no_gaps;
    bit          hold_req;
    int          items_sent;
    int          mismatches;
    int unsigned cycle_count;

    t_stim_row directed_rows [15] = '{
        '{">/", 1'b1, '{8'd45, 8'd45, 8'd45, 8'd45, 8'd127}},
        '{">1000:1000:1000:1000:1/", 1'b1, '{8'd140, 8'd140, 8'd140, 8'd140, 8'd127}},
        '{">0:0:0:0:2/", 1'b1, '{8'd45, 8'd45, 8'd45, 8'd45, 8'd94}},
        '{">999:1:500:1001:3/", 1'b1, '{8'd139, 8'd45, 8'd92, 8'd140, 8'd62}},
        '{">5:6:7:8:4/", 1'b1, '{8'd45, 8'd45, 8'd45, 8'd45, 8'd62}},
        '{">99999:12a34:a5::7:0/", 1'b1, '{8'd140, 8'd46, 8'd45, 8'd45, 8'd62}},
        '{" .>1 0.0\0370!:/", 1'b1, '{8'd140, 8'd45, 8'd45, 8'd45, 8'd62}},
        '{">12>34/", 1'b1, '{8'd140, 8'd45, 8'd45, 8'd45, 8'd62}},
        '{"123:/abc", 1'b0, '0},
        '{">1:2:3:4:1:9:9:9/", 1'b1, '{8'd45, 8'd45, 8'd45, 8'd45, 8'd127}},
        '{">\3777:\2008/", 1'b0, '0},
        '{">::1:2:3:4:12/", 1'b1, '{8'd45, 8'd45, 8'd45, 8'd45, 8'd127}},
        '{">500:500:500:500:02/", 1'b1, '{8'd92, 8'd92, 8'd92, 8'd92, 8'd94}},
        '{">12:34", 1'b0, '0},
        '{">56/", 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [ANGLE_W-1:0] stick_angle(input logic [VALUE_W-1:0] v);
        int unsigned x;
        x = (v > VALUE_MAX) ? VALUE_MAX : v;
        return ANGLE_BASE + ANGLE_W'((x * STICK_SPAN) / VALUE_MAX);
    endfunction

    function automatic void clear_frame();
        field_pos      = '0;
        token_open     = 1'b0;
        digits_stopped = 1'b0;
        mode_val       = '0;
        for (int k = 0; k < NUM_STICKS; k++) stick_val[k] = '0;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int seen);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, seen);
        mismatches++;
    endtask

    // Advances the frame state by one received byte; done is set when the byte closes a frame.
    task automatic track_frame_byte(input logic [BYTE_W-1:0] b, output bit done,
                                    output t_angles out);
        int unsigned v;
        done = 1'b0;
        out  = '0;
        if (b < LOW_LIMIT) return;
        if (awaiting_start) begin
            if (b == CH_START) awaiting_start = 1'b0;
            return;
        end
        if (b == CH_START) return;
        if (b == CH_END) begin
            case (mode_val)
                MODE_GPS:      held_angle = gps_angle_reg;
                MODE_ATTITUDE: held_angle = att_angle_reg;
                MODE_MANUAL:   held_angle = man_angle_reg;
                default: ;
            endcase
            out.aileron  = stick_angle(stick_val[0]);
            out.elevator = stick_angle(stick_val[1]);
            out.throttle = stick_angle(stick_val[2]);
            out.rudder   = stick_angle(stick_val[3]);
            out.mode     = held_angle;
            done = 1'b1;
            clear_frame();
            awaiting_start = 1'b1;
            return;
        end
        if (b == CH_SEP) begin
            if (token_open && field_pos < FIELD_LIMIT) field_pos++;
            token_open     = 1'b0;
            digits_stopped = 1'b0;
            return;
        end
        if (!token_open) begin
            token_open     = 1'b1;
            digits_stopped = 1'b0;
        end
        if (b >= CH_ZERO && b <= CH_NINE && !digits_stopped) begin
            if (field_pos < MODE_FIELD) begin
                v = int'(stick_val[field_pos]) * 10 + int'(b - CH_ZERO);
                if (v > VALUE_MAX) v = VALUE_MAX;
                stick_val[field_pos] = VALUE_W'(v);
            end else if (field_pos == MODE_FIELD) begin
                v = int'(mode_val) * 10 + int'(b - CH_ZERO);
                if (v > MODE_SAT) v = MODE_SAT;
                mode_val = MODE_W'(v);
            end
        end else begin
            digits_stopped = 1'b1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        bit      done;
        t_angles got;
        int      gap;
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge i_clk);
        while (!rx.ready) @(posedge i_clk);
        items_sent++;
        track_frame_byte(b, done, got);
        if (done) begin
            if (typed_pending) begin
                expected_angles.push_back(typed_want);
                typed_pending = 1'b0;
            end else begin
                expected_angles.push_back(got);
            end
        end
        gap = pick_gap();
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_field(input bit is_mode);
        string text;
        int    pick;
        pick = $urandom_range(0, 9);
        if (is_mode) begin
            if (pick < 7) text = $sformatf("%0d", $urandom_range(0, 5));
            else if (pick < 9) text = $sformatf("0%0d", $urandom_range(0, 3));
            else text = $sformatf("%0d", $urandom_range(6, 99));
        end else begin
            if (pick < 5) text = $sformatf("%0d", $urandom_range(0, 1000));
            else if (pick < 7) text = $sformatf("%0d", $urandom_range(990, 1010));
            else if (pick < 8) text = $sformatf("%0d", $urandom_range(0, 9999999));
            else if (pick < 9) text = $sformatf("00%0d", $urandom_range(0, 99));
            else text = "";
        end
        for (int k = 0; k < text.len(); k++) begin
            if ($urandom_range(0, 11) == 0) send_byte(BYTE_W'($urandom_range(0, LOW_LIMIT - 1)));
            if ($urandom_range(0, 49) == 0) send_byte(CH_START);
            send_byte(text[k]);
        end
        // A non-digit other than '>' ends the digit run; the digit after it must be ignored.
        if ($urandom_range(0, 9) == 0) begin
            send_byte(BYTE_W'($urandom_range(CH_SEP + 1, 255)));
            send_byte(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic send_frame();
        int fields;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(CH_START);
        fields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
        for (int f = 0; f < fields; f++) begin
            if (f > 0) send_byte(CH_SEP);
            if ($urandom_range(0, 9) == 0) send_byte(CH_SEP);
            send_field(f == MODE_FIELD);
        end
        // Now and then the frame is left open and runs into the next one.
        if ($urandom_range(0, 19) != 0) send_byte(CH_END);
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        rx.valid <= 1'b0;
        while (expected_angles.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_angles.size() != 0) begin
            report_mismatch("results still pending", 0, expected_angles.size());
            expected_angles.delete();
        end
    endtask

    task automatic load_mode_angles(input logic [ANGLE_W-1:0] gps, att, man);
        logic [CFG_IDX_W-1:0] idx_list [4];
        logic [ANGLE_W-1:0]   val_list [4];
        idx_list = '{CFG_GPS, CFG_ATTITUDE, CFG_SPARE, CFG_MANUAL};
        val_list = '{gps, att, ANGLE_W'($urandom_range(0, 255)), man};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
            case (idx_list[k])
                CFG_GPS:      gps_angle_reg = val_list[k];
                CFG_ATTITUDE: att_angle_reg = val_list[k];
                CFG_MANUAL:   man_angle_reg = val_list[k];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int target;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        rx.valid       = 1'b0;
        rx.rx_byte     = '0;
        no_gaps        = 1'b0;
        hold_req       = 1'b0;
        typed_pending  = 1'b0;
        typed_want     = '0;
        items_sent     = 0;
        mismatches     = 0;
        gps_angle_reg  = GPS_RESET;
        att_angle_reg  = ATTITUDE_RESET;
        man_angle_reg  = MANUAL_RESET;
        held_angle     = HELD_RESET;
        awaiting_start = 1'b1;
        clear_frame();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            typed_pending = directed_rows[r].typed;
            typed_want    = directed_rows[r].want;
            for (int k = 0; k < directed_rows[r].text.len(); k++)
                send_byte(directed_rows[r].text[k]);
        end
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_mode_angles(8'd0, 8'd0, 8'd0);
                1: load_mode_angles(8'd255, 8'd255, 8'd255);
                2: load_mode_angles(8'd180, 8'd1, 8'd179);
                default: load_mode_angles(ANGLE_W'($urandom_range(0, 255)),
                                          ANGLE_W'($urandom_range(0, 255)),
                                          ANGLE_W'($urandom_range(0, 180)));
            endcase
            if (p == 2) begin
                // Short frames back to back while the result side holds off, so the
                // block fills up and has to stall its input.
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                repeat (FLOOD_FRAMES) begin
                    send_byte(CH_START);
                    send_byte(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
                    send_byte(CH_END);
                end
            end
            no_gaps = (p == 1 || p == 4);
            target  = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) send_frame();
            send_byte(CH_END);
            no_gaps = 1'b0;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("PASS rc_command_frame_parser");
        end else begin
            $display("FAIL rc_command_frame_parser");
        end
        $finish;
    end

    initial begin : result_side
        int stall;
        int r;
        stall     = 0;
        res.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                res.ready <= 1'b0;
                stall--;
            end else if (no_gaps) begin
                res.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    res.ready <= 1'b1;
                end else begin
                    res.ready <= 1'b0;
                    stall = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 50);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_angles want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("transfer with no result pending", -1, res.mode_angle);
            end else begin
                want = expected_angles.pop_front();
                if (res.aileron_angle !== want.aileron)
                    report_mismatch("aileron_angle", want.aileron, res.aileron_angle);
                if (res.elevator_angle !== want.elevator)
                    report_mismatch("elevator_angle", want.elevator, res.elevator_angle);
                if (res.throttle_angle !== want.throttle)
                    report_mismatch("throttle_angle", want.throttle, res.throttle_angle);
                if (res.rudder_angle !== want.rudder)
                    report_mismatch("rudder_angle", want.rudder, res.rudder_angle);
                if (res.mode_angle !== want.mode)
                    report_mismatch("mode_angle", want.mode, res.mode_angle);
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rc_command_frame_parser");
            $finish;
        end
    end

endmodule

[sim.f]
design/rcf_pkg.sv
design/rcf_rx_if.sv
design/rcf_res_if.sv
design/rc_command_frame_parser.sv
dv/tb.sv
